FILE: rtl/sstq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sstq_pkg;

    localparam int QUEUE_SLOTS = 128;
    localparam int IDX_W       = $clog2(QUEUE_SLOTS);
    localparam int QNOW_W      = 7;
    localparam int CNT_W       = (IDX_W + 1 > QNOW_W) ? IDX_W + 1 : QNOW_W;
    localparam int SVC_W       = 8;
    localparam int ID_W        = 32;
    localparam int TIME_W      = 32;
    localparam int WSUM_W      = 48;
    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 2;

    localparam logic [SVC_W-1:0] MAX_SERVICE_RST = SVC_W'(10);

    typedef struct packed {
        logic             arrival;
        logic [SVC_W-1:0] svc;
    } t_tick;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sstq_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sstq_front
    import sstq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_arrival,
    input  wire logic [SVC_W-1:0] i_service_time,
    input  wire logic [SVC_W-1:0] i_max_service,
    output logic                  o_q_valid,
    output t_tick                 o_q_data,
    input  wire logic             i_q_ready
);

    logic             r_valid;
    t_tick            r_tick;
    logic             w_accept;
    logic [SVC_W-1:0] n_svc;

    assign o_stall   = r_valid && !i_q_ready;
    assign w_accept  = i_valid && !o_stall;
    assign o_q_valid = r_valid;
    assign o_q_data  = r_tick;

    // clamp to the register, never below one
    always_comb begin
        n_svc = (i_service_time > i_max_service) ? i_max_service : i_service_time;
        if (n_svc == '0) begin
            n_svc = SVC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tick.arrival <= i_arrival;
            r_tick.svc     <= n_svc;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sstq_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module sstq_fifo
    import sstq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_tick i_data,
    output logic       o_ready,
    output logic       o_valid,
    output t_tick      o_data,
    input  wire logic  i_pop
);

    t_tick              r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0]  r_wp;
    logic [FPTR_W-1:0]  r_rp;
    logic [FCNT_W-1:0]  r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_cnt != FCNT_W'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sstq_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sstq_back
    import sstq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_tick             i_q_data,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_started,
    output logic [ID_W-1:0]        o_started_id,
    output logic [TIME_W-1:0]      o_wait_ticks,
    output logic [ID_W-1:0]        o_served_total,
    output logic [WSUM_W-1:0]      o_wait_total,
    output logic [QNOW_W-1:0]      o_queued_now,
    output logic                   o_overflow
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SUM
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_head;
    logic [IDX_W-1:0]    r_tail;
    logic [TIME_W-1:0]   r_time;
    logic [ID_W-1:0]     r_event;
    logic [ID_W-1:0]     r_served;
    logic [SVC_W-1:0]    r_rem;
    logic [WSUM_W-1:0]   r_wsum;
    logic                r_out_valid;

    logic                r_tk_start;
    logic                r_tk_ovf;
    logic [ID_W-1:0]     r_tk_id;
    logic [TIME_W-1:0]   r_tk_wait;
    logic [SVC_W-1:0]    r_tk_svc;

    logic [ID_W-1:0]     mem_id   [QUEUE_SLOTS];
    logic [TIME_W-1:0]   mem_time [QUEUE_SLOTS];
    logic [SVC_W-1:0]    mem_svc  [QUEUE_SLOTS];
    logic [ID_W-1:0]     r_rd_id;
    logic [TIME_W-1:0]   r_rd_time;
    logic [SVC_W-1:0]    r_rd_svc;

    logic [IDX_W-1:0]    n_tail_nx;
    logic [IDX_W-1:0]    n_head_nx;
    logic [IDX_W-1:0]    n_tail;
    logic                n_full;
    logic                n_enq;
    logic                n_start;
    logic                n_fwd;
    logic [ID_W-1:0]     n_id;
    logic                w_take;
    logic                w_commit;
    logic [WSUM_W:0]     n_sum;
    logic [CNT_W-1:0]    n_occ;
    logic [SVC_W-1:0]    n_rem;

    assign n_tail_nx = next_slot(r_tail);
    assign n_head_nx = next_slot(r_head);
    assign n_full    = (n_tail_nx == r_head);
    assign n_enq     = i_q_data.arrival && !n_full;
    assign n_tail    = n_enq ? n_tail_nx : r_tail;
    assign n_start   = (r_head != n_tail) && (r_rem == '0);
    // queue was empty, so if the server is idle the new arrival starts at once
    assign n_fwd     = n_enq && (r_head == r_tail);
    assign n_id      = r_event + 1'b1;

    assign w_take    = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop   = w_take;
    assign w_commit  = (r_state == S_SUM) && (!r_out_valid || !i_stall);
    assign o_valid   = r_out_valid;

    assign n_sum = {1'b0, r_wsum} + (WSUM_W + 1)'(r_tk_wait);

    always_comb begin
        n_occ = CNT_W'(r_tail) - CNT_W'(r_head);
        if (r_tail < r_head) begin
            n_occ = n_occ + CNT_W'(QUEUE_SLOTS);
        end
    end

    always_comb begin
        if (r_tk_start) begin
            n_rem = r_tk_svc - 1'b1;
        end else if (r_rem != '0) begin
            n_rem = r_rem - 1'b1;
        end else begin
            n_rem = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && n_enq) begin
            mem_id[n_tail_nx]   <= n_id;
            mem_time[n_tail_nx] <= r_time;
            mem_svc[n_tail_nx]  <= i_q_data.svc;
        end
        if (w_take && n_start) begin
            r_rd_id   <= mem_id[n_head_nx];
            r_rd_time <= mem_time[n_head_nx];
            r_rd_svc  <= mem_svc[n_head_nx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_time      <= '0;
            r_event     <= '0;
            r_served    <= '0;
            r_rem       <= '0;
            r_wsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !w_commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_tk_start <= n_start;
                        r_tk_ovf   <= i_q_data.arrival && n_full;
                        r_tk_id    <= n_id;
                        r_tk_wait  <= '0;
                        r_tk_svc   <= i_q_data.svc;
                        r_tail     <= n_tail;
                        if (n_enq) begin
                            r_event <= n_id;
                        end
                        if (n_start) begin
                            r_head <= n_head_nx;
                        end
                        r_state <= (n_start && !n_fwd) ? S_READ : S_SUM;
                    end
                end
                S_READ: begin
                    r_tk_id   <= r_rd_id;
                    r_tk_wait <= r_time - r_rd_time;
                    r_tk_svc  <= r_rd_svc;
                    r_state   <= S_SUM;
                end
                S_SUM: begin
                    if (w_commit) begin
                        r_out_valid    <= 1'b1;
                        o_started      <= r_tk_start;
                        o_started_id   <= r_tk_start ? r_tk_id : '0;
                        o_wait_ticks   <= r_tk_start ? r_tk_wait : '0;
                        o_served_total <= r_served + ID_W'(r_tk_start);
                        o_queued_now   <= n_occ[QNOW_W-1:0];
                        o_overflow     <= r_tk_ovf;
                        if (r_tk_start) begin
                            r_served <= r_served + 1'b1;
                            r_wsum   <= n_sum[WSUM_W] ? '1 : n_sum[WSUM_W-1:0];
                            o_wait_total <= n_sum[WSUM_W] ? '1 : n_sum[WSUM_W-1:0];
                        end else begin
                            o_wait_total <= r_wsum;
                        end
                        r_rem   <= n_rem;
                        r_time  <= r_time + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/single_server_queue_tick_model_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// ticks     in         i_valid / o_stall    i_arrival, i_service_time
// results   out        o_valid / i_stall    o_started .. o_overflow
// config    in         apb psel/penable     max_service at byte 0
//
// an item is registered, queued two deep, then run by the back sequencer:
// idle then sum for a tick with no start or a start straight from an arrival,
// idle, read, sum when the head comes from the slot memory (registered read)
// reset is synchronous; the slot memory is not cleared
// a stalled result holds in the output register; the front keeps taking
// items until the two-deep queue and the front register fill
module single_server_queue_tick_model_top
    import sstq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_arrival,
    input  wire logic [SVC_W-1:0]  i_service_time,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_started,
    output logic [ID_W-1:0]        o_started_id,
    output logic [TIME_W-1:0]      o_wait_ticks,
    output logic [ID_W-1:0]        o_served_total,
    output logic [WSUM_W-1:0]      o_wait_total,
    output logic [QNOW_W-1:0]      o_queued_now,
    output logic                   o_overflow,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [SVC_W-1:0] r_max_service;
    logic             w_fq_valid;
    t_tick            w_fq_data;
    logic             w_fq_ready;
    logic             w_bq_valid;
    t_tick            w_bq_data;
    logic             w_bq_pop;

    assign pready = 1'b1;
    // one register; writes ignore paddr, reads return it only at offset 0
    assign prdata = (paddr == '0) ? APB_DW'(r_max_service) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_service <= MAX_SERVICE_RST;
        end else if (psel && penable && pwrite && pready) begin
            r_max_service <= pwdata[SVC_W-1:0];
        end
    end

    sstq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_arrival      (i_arrival),
        .i_service_time (i_service_time),
        .i_max_service  (r_max_service),
        .o_q_valid      (w_fq_valid),
        .o_q_data       (w_fq_data),
        .i_q_ready      (w_fq_ready)
    );

    sstq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_valid),
        .i_data  (w_fq_data),
        .o_ready (w_fq_ready),
        .o_valid (w_bq_valid),
        .o_data  (w_bq_data),
        .i_pop   (w_bq_pop)
    );

    sstq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_bq_valid),
        .i_q_data       (w_bq_data),
        .o_q_pop        (w_bq_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_started      (o_started),
        .o_started_id   (o_started_id),
        .o_wait_ticks   (o_wait_ticks),
        .o_served_total (o_served_total),
        .o_wait_total   (o_wait_total),
        .o_queued_now   (o_queued_now),
        .o_overflow     (o_overflow)
    );

endmodule
`default_nettype wire

FILE: rtl/sstq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sstq_props
    import sstq_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic              o_started,
    input wire logic [ID_W-1:0]   o_started_id,
    input wire logic [TIME_W-1:0] o_wait_ticks,
    input wire logic [ID_W-1:0]   o_served_total,
    input wire logic [WSUM_W-1:0] o_wait_total
);

    logic [ID_W-1:0]   r_prev_served;
    logic [WSUM_W-1:0] r_prev_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_served <= '0;
            r_prev_total  <= '0;
        end else if (o_valid && !i_stall) begin
            r_prev_served <= o_served_total;
            r_prev_total  <= o_wait_total;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_wait_total) && $stable(o_started_id))
        else $error("result changed while stalled");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_started |-> o_started_id == '0 && o_wait_ticks == '0)
        else $error("id or wait set without a start");

    a_served_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_served_total == r_prev_served + ID_W'(o_started))
        else $error("served count does not follow starts");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_wait_total >= r_prev_total)
        else $error("wait total went down");

endmodule

bind single_server_queue_tick_model_top sstq_props u_sstq_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_started      (o_started),
    .o_started_id   (o_started_id),
    .o_wait_ticks   (o_wait_ticks),
    .o_served_total (o_served_total),
    .o_wait_total   (o_wait_total)
);
`default_nettype wire

FILE: verif/sstq_checker.sv
`timescale 1ns / 1ps
module sstq_checker
    import sstq_pkg::*;
#(
    parameter logic [APB_AW-1:0] MAX_SERVICE_ADDR = '0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              o_stall,
    input  wire logic              i_arrival,
    input  wire logic [SVC_W-1:0]  i_service_time,
    input  wire logic              o_valid,
    input  wire logic              i_stall,
    input  wire logic              o_started,
    input  wire logic [ID_W-1:0]   o_started_id,
    input  wire logic [TIME_W-1:0] o_wait_ticks,
    input  wire logic [ID_W-1:0]   o_served_total,
    input  wire logic [WSUM_W-1:0] o_wait_total,
    input  wire logic [QNOW_W-1:0] o_queued_now,
    input  wire logic              o_overflow,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    input  wire logic              pready,
    output int                     mismatches,
    output int                     outstanding
);

    localparam logic [SVC_W-1:0]  SERVICE_CAP_RESET = SVC_W'(10);
    localparam logic [WSUM_W-1:0] WAIT_SUM_MAX      = '1;

    typedef struct packed {
        logic              started;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] wait_ticks;
        logic [ID_W-1:0]   served_total;
        logic [WSUM_W-1:0] wait_total;
        logic [QNOW_W-1:0] queued_now;
        logic              overflow;
    } t_tick_outcome;

    logic [ID_W-1:0]   slot_ids      [QUEUE_SLOTS];
    logic [TIME_W-1:0] slot_arrivals [QUEUE_SLOTS];
    logic [SVC_W-1:0]  slot_services [QUEUE_SLOTS];
    int                head_slot;
    int                tail_slot;
    logic [TIME_W-1:0] tick_now;
    logic [ID_W-1:0]   last_id;
    logic [ID_W-1:0]   served_cnt;
    logic [SVC_W-1:0]  busy_ticks;
    logic [WSUM_W-1:0] wait_acc;
    logic [SVC_W-1:0]  service_cap;

    t_tick_outcome     tick_outcomes [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic run_tick(input logic arrival, input logic [SVC_W-1:0] svc_in,
                            output t_tick_outcome res);
        logic [SVC_W-1:0]  svc;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] waited;
        int                next_tail;
        now = tick_now;
        res = '0;
        if (arrival) begin
            svc = (svc_in > service_cap) ? service_cap : svc_in;
            if (svc == 0)
                svc = SVC_W'(1);
            next_tail = (tail_slot + 1) % QUEUE_SLOTS;
            if (next_tail == head_slot) begin
                res.overflow = 1'b1;
            end else begin
                last_id                  = last_id + 1;
                tail_slot                = next_tail;
                slot_ids[tail_slot]      = last_id;
                slot_arrivals[tail_slot] = now;
                slot_services[tail_slot] = svc;
            end
        end
        if (head_slot != tail_slot && busy_ticks == 0) begin
            head_slot      = (head_slot + 1) % QUEUE_SLOTS;
            waited         = now - slot_arrivals[head_slot];
            res.started    = 1'b1;
            res.id         = slot_ids[head_slot];
            res.wait_ticks = waited;
            busy_ticks     = slot_services[head_slot];
            served_cnt     = served_cnt + 1;
            if (WAIT_SUM_MAX - wait_acc < WSUM_W'(waited))
                wait_acc = WAIT_SUM_MAX;
            else
                wait_acc = wait_acc + WSUM_W'(waited);
        end
        if (busy_ticks > 0)
            busy_ticks = busy_ticks - 1'b1;
        tick_now         = now + 1;
        res.served_total = served_cnt;
        res.wait_total   = wait_acc;
        res.queued_now   = QNOW_W'((tail_slot + QUEUE_SLOTS - head_slot) % QUEUE_SLOTS);
    endtask

    always @(posedge i_clk) begin : watch
        t_tick_outcome got;
        t_tick_outcome want;
        if (!i_rst_n) begin
            head_slot   = 0;
            tail_slot   = 0;
            tick_now    = '0;
            last_id     = '0;
            served_cnt  = '0;
            busy_ticks  = '0;
            wait_acc    = '0;
            service_cap = SERVICE_CAP_RESET;
            tick_outcomes.delete();
            outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == MAX_SERVICE_ADDR)
                service_cap = pwdata[SVC_W-1:0];
            if (o_valid && !i_stall) begin
                got.started      = o_started;
                got.id           = o_started_id;
                got.wait_ticks   = o_wait_ticks;
                got.served_total = o_served_total;
                got.wait_total   = o_wait_total;
                got.queued_now   = o_queued_now;
                got.overflow     = o_overflow;
                if (tick_outcomes.size() == 0) begin
                    report_mismatch("result with nothing expected", 64'(got.id), '0);
                end else begin
                    want = tick_outcomes.pop_front();
                    if (got.started !== want.started)
                        report_mismatch("started", 64'(got.started), 64'(want.started));
                    if (got.id !== want.id)
                        report_mismatch("started_id", 64'(got.id), 64'(want.id));
                    if (got.wait_ticks !== want.wait_ticks)
                        report_mismatch("wait_ticks", 64'(got.wait_ticks),
                                        64'(want.wait_ticks));
                    if (got.served_total !== want.served_total)
                        report_mismatch("served_total", 64'(got.served_total),
                                        64'(want.served_total));
                    if (got.wait_total !== want.wait_total)
                        report_mismatch("wait_total", 64'(got.wait_total),
                                        64'(want.wait_total));
                    if (got.queued_now !== want.queued_now)
                        report_mismatch("queued_now", 64'(got.queued_now),
                                        64'(want.queued_now));
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
                end
            end
            if (i_valid && !o_stall) begin
                run_tick(i_arrival, i_service_time, want);
                tick_outcomes.push_back(want);
            end
            outstanding <= tick_outcomes.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
    import sstq_pkg::*;

    localparam logic [APB_AW-1:0] MAX_SERVICE_ADDR = APB_AW'(0);
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 225;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_arrival;
    logic [SVC_W-1:0]  i_service_time;
    logic              o_valid;
    logic              i_stall;
    logic              o_started;
    logic [ID_W-1:0]   o_started_id;
    logic [TIME_W-1:0] o_wait_ticks;
    logic [ID_W-1:0]   o_served_total;
    logic [WSUM_W-1:0] o_wait_total;
    logic [QNOW_W-1:0] o_queued_now;
    logic              o_overflow;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                mismatches;
    int                outstanding;
    int                cycles = 0;
    logic [SVC_W-1:0]  cur_cap = SVC_W'(10);
    bit                gapless = 1'b0;

    single_server_queue_tick_model_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_arrival      (i_arrival),
        .i_service_time (i_service_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_started      (o_started),
        .o_started_id   (o_started_id),
        .o_wait_ticks   (o_wait_ticks),
        .o_served_total (o_served_total),
        .o_wait_total   (o_wait_total),
        .o_queued_now   (o_queued_now),
        .o_overflow     (o_overflow),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    sstq_checker #(
        .MAX_SERVICE_ADDR (MAX_SERVICE_ADDR)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_arrival      (i_arrival),
        .i_service_time (i_service_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_started      (o_started),
        .o_started_id   (o_started_id),
        .o_wait_ticks   (o_wait_ticks),
        .o_served_total (o_served_total),
        .o_wait_total   (o_wait_total),
        .o_queued_now   (o_queued_now),
        .o_overflow     (o_overflow),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver backpressure: mostly short stalls, a few long ones, free runs mostly short, some long
    initial begin : receiver
        forever begin
            i_stall <= 1'b0;
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(300, 50)) @(posedge i_clk);
            else
                repeat ($urandom_range(8, 1)) @(posedge i_clk);
            i_stall <= 1'b1;
            if ($urandom_range(19) == 0)
                repeat ($urandom_range(60, 20)) @(posedge i_clk);
            else
                repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    end

    function automatic int pick_gap();
        int roll;
        if (gapless)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [SVC_W-1:0] pick_service();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            case ($urandom_range(5))
                0: return '0;
                1: return SVC_W'(1);
                2: return cur_cap - 1'b1;
                3: return cur_cap;
                4: return cur_cap + 1'b1;
                default: return '1;
            endcase
        end
        if (roll < 30 && cur_cap > 0)
            return SVC_W'($urandom_range(cur_cap, 1));
        return SVC_W'($urandom_range(255));
    endfunction

    task automatic send_tick(input logic arrival, input logic [SVC_W-1:0] svc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_arrival      <= arrival;
        i_service_time <= svc;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop sending and let every expected result drain out
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_max_service(input logic [SVC_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_SERVICE_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_cap = value;
    endtask

    initial begin : stimulus
        int cap_values  [PHASES];
        int arrive_pcts [PHASES];
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_arrival      <= 1'b0;
        i_service_time <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        cap_values  = '{1, 0, 3, 0, 255, 128, 0, 10};
        arrive_pcts = '{50, 95, 60, 0, 90, 30, 0, 70};
        cap_values[3]  = $urandom_range(254, 2);
        cap_values[6]  = $urandom_range(254, 2);
        arrive_pcts[3] = $urandom_range(100, 5);
        arrive_pcts[6] = $urandom_range(100, 5);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset cap of 10: zero raised to one, clamping, start on arrival tick
        send_tick(1'b0, 8'h00);
        send_tick(1'b1, 8'h00);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b1, 8'h01);
        send_tick(1'b1, 8'h0A);
        send_tick(1'b1, 8'h0B);
        send_tick(1'b1, 8'h55);
        send_tick(1'b1, 8'hAA);
        send_tick(1'b0, 8'hFF);
        repeat (14) send_tick(1'b0, 8'h80);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_max_service(SVC_W'(cap_values[p]));
            gapless = (p == 1 || p == 5);
            for (int i = 0; i < PHASE_TICKS; i++) begin
                if (p == 3 && i == PHASE_TICKS / 2)
                    settle();
                send_tick($urandom_range(99) < arrive_pcts[p], pick_service());
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
